FILE: design/cfm_pkg.sv
// shared widths and types for the curve moving frame block
package cfm_pkg;

    // fraction bits of a unit vector component
    localparam int FRAC    = 14;
    // width of one unit vector component, sign and integer bit included
    localparam int OUT_W   = FRAC + 2;
    // point coordinate width
    localparam int PT_W    = 32;
    // widest raw vector component (second cross product of the normal)
    localparam int RAW_W   = 48;
    // magnitude bits after fitting into [2^29, 2^30)
    localparam int FIT_W   = 30;
    // signed fitted component, also the wide cross operand
    localparam int BW      = FIT_W + 1;
    // sum of three squares of fitted magnitudes
    localparam int SUM_W   = 2 * FIT_W + 2;
    // integer square root of the sum
    localparam int N_W     = FIT_W + 1;
    // dividend of one output component
    localparam int NUM_W   = FIT_W + FRAC + 1;
    // quotient bits kept
    localparam int Q_W     = FRAC + 2;
    // divider step counter
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    // component type of a unit vector
    typedef logic signed [OUT_W-1:0] comp_t;
    // raw vector component
    typedef logic signed [RAW_W-1:0] raw_t;
    // wide cross operand / fitted component
    typedef logic signed [BW-1:0]    wide_t;

endpackage

FILE: design/cfm_if.sv
// point and frame channel interfaces
interface cfm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [cfm_pkg::PT_W-1:0]   point_x;
    logic signed [cfm_pkg::PT_W-1:0]   point_y;
    logic signed [cfm_pkg::PT_W-1:0]   point_z;
    logic                              final_point;

    modport source  (output valid, point_x, point_y, point_z, final_point, input ready);
    modport sink    (input valid, point_x, point_y, point_z, final_point, output ready);
    modport monitor (input valid, ready, point_x, point_y, point_z, final_point);
endinterface

interface cfm_out_if;
    logic                 valid;
    logic                 ready;
    cfm_pkg::comp_t       tangent_x;
    cfm_pkg::comp_t       tangent_y;
    cfm_pkg::comp_t       tangent_z;
    cfm_pkg::comp_t       normal_x;
    cfm_pkg::comp_t       normal_y;
    cfm_pkg::comp_t       normal_z;
    cfm_pkg::comp_t       binormal_x;
    cfm_pkg::comp_t       binormal_y;
    cfm_pkg::comp_t       binormal_z;
    logic                 frame_last;
    logic                 degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, normal_x, normal_y,
                    normal_z, binormal_x, binormal_y, binormal_z, frame_last, degenerate,
                    input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, normal_x, normal_y,
                    normal_z, binormal_x, binormal_y, binormal_z, frame_last, degenerate,
                    output ready);
    modport monitor (input valid, ready, tangent_x, tangent_y, tangent_z, normal_x,
                     normal_y, normal_z, binormal_x, binormal_y, binormal_z, frame_last,
                     degenerate);
endinterface

FILE: design/curve_moving_frame.sv
// curve moving frame: tangent, normal and binormal per curve point
//
//  channel   dir   fields
//  in_ch     in    point_x/y/z (Q16.16), final_point
//  out_ch    out   tangent/normal/binormal x/y/z (Q1.14), frame_last, degenerate
//  cfg       in    cfg_we, cfg_wdata (consistent normal mode)
//
// a normalizer pass finds the fit shift bit by bit, squares the three fitted
// components, takes a bit-serial root and divides each component in turn; a frame
// runs it for the tangent, normal and binormal with a binormal cross product, and
// consistent mode adds, past the first frame, a fit-only pass and two more cross
// products; the final point runs the normal and binormal again.
// in_ch is ready only while the sequencer is idle; a finished frame waits
// in the output register and the sequencer stalls before emitting the next
// frame until it is taken. reset clears the curve state and sets consistent mode.
module curve_moving_frame
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    cfm_in_if.sink             in_ch,
    cfm_out_if.source          out_ch
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DEGEN  = 4'd1;
    localparam logic [3:0] ST_TAN    = 4'd2;
    localparam logic [3:0] ST_SETUP  = 4'd3;
    localparam logic [3:0] ST_CROSS1 = 4'd4;
    localparam logic [3:0] ST_FIT    = 4'd5;
    localparam logic [3:0] ST_CROSS2 = 4'd6;
    localparam logic [3:0] ST_NNORM  = 4'd7;
    localparam logic [3:0] ST_BCROSS = 4'd8;
    localparam logic [3:0] ST_BNORM  = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0]                  state_reg;
    logic                        mode_reg;
    logic [1:0]                  seen_reg;
    logic                        fin_reg;
    logic                        first_reg;
    logic                        pass_reg;
    logic                        norm_go_reg;
    logic                        cross_go_reg;
    logic signed [cfm_pkg::PT_W-1:0] held_reg [3];
    cfm_pkg::comp_t              pt_reg [3];
    cfm_pkg::comp_t              pn_reg [3];
    cfm_pkg::comp_t              t_reg [3];
    cfm_pkg::comp_t              n_reg [3];
    cfm_pkg::comp_t              b_reg [3];
    cfm_pkg::raw_t               raw_reg [3];
    cfm_pkg::wide_t              sc_reg [3];
    logic                        ov_reg;
    cfm_pkg::comp_t              ot_reg [3];
    cfm_pkg::comp_t              on_reg [3];
    cfm_pkg::comp_t              ob_reg [3];
    logic                        olast_reg;
    logic                        odeg_reg;

    logic                        accept;
    logic                        out_free;
    logic signed [cfm_pkg::PT_W-1:0] pin [3];
    cfm_pkg::comp_t              xa [3];
    cfm_pkg::wide_t              xb [3];
    cfm_pkg::raw_t               xo [3];
    logic                        x_done;
    cfm_pkg::comp_t              nres [3];
    cfm_pkg::wide_t              nfit [3];
    logic                        n_done;
    cfm_pkg::raw_t               diff [3];
    logic                        diff_zero;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !ov_reg || out_ch.ready;
    assign pin[0]   = in_ch.point_x;
    assign pin[1]   = in_ch.point_y;
    assign pin[2]   = in_ch.point_z;

    // cross operand select
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (state_reg)
                ST_CROSS1:
                begin
                    xa[k] = pn_reg[k];
                    xb[k] = cfm_pkg::BW'(t_reg[k]);
                end
                ST_CROSS2:
                begin
                    xa[k] = t_reg[k];
                    xb[k] = sc_reg[k];
                end
                default:
                begin
                    xa[k] = t_reg[k];
                    xb[k] = cfm_pkg::BW'(n_reg[k]);
                end
            endcase
        end
    end

    // tangent difference for the non-consistent normal
    always_comb
    begin
        diff_zero = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            diff[k]   = cfm_pkg::RAW_W'(t_reg[k]) - cfm_pkg::RAW_W'(pt_reg[k]);
            diff_zero = diff_zero & (diff[k] == '0);
        end
    end

    cfm_cross u_cross
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cross_go_reg),
        .a     (xa),
        .b     (xb),
        .o     (xo),
        .done  (x_done)
    );

    cfm_norm u_norm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (norm_go_reg),
        .fit_only (state_reg == ST_FIT),
        .vec      (raw_reg),
        .res      (nres),
        .fit      (nfit),
        .done     (n_done)
    );

    // sequencer and curve state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b1;
            seen_reg     <= '0;
            fin_reg      <= 1'b0;
            first_reg    <= 1'b0;
            pass_reg     <= 1'b0;
            norm_go_reg  <= 1'b0;
            cross_go_reg <= 1'b0;
            ov_reg       <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                held_reg[k] <= '0;
                pt_reg[k]   <= '0;
                pn_reg[k]   <= '0;
            end
        end
        else
        begin
            norm_go_reg  <= 1'b0;
            cross_go_reg <= 1'b0;
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (seen_reg == 2'd0)
                        begin
                            if (in_ch.final_point)
                                state_reg <= ST_DEGEN;
                            else
                            begin
                                seen_reg <= 2'd1;
                                for (int k = 0; k < 3; k++)
                                    held_reg[k] <= pin[k];
                            end
                        end
                        else
                        begin
                            fin_reg     <= in_ch.final_point;
                            first_reg   <= seen_reg == 2'd1;
                            pass_reg    <= 1'b0;
                            norm_go_reg <= 1'b1;
                            state_reg   <= ST_TAN;
                            for (int k = 0; k < 3; k++)
                                held_reg[k] <= pin[k];
                        end
                    end
                end
                ST_DEGEN:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                        seen_reg  <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            held_reg[k] <= '0;
                            pt_reg[k]   <= '0;
                            pn_reg[k]   <= '0;
                        end
                    end
                end
                ST_TAN:
                begin
                    if (n_done)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    if (!first_reg && mode_reg)
                    begin
                        cross_go_reg <= 1'b1;
                        state_reg    <= ST_CROSS1;
                    end
                    else
                    begin
                        norm_go_reg <= 1'b1;
                        state_reg   <= ST_NNORM;
                    end
                end
                ST_CROSS1:
                begin
                    if (x_done)
                    begin
                        norm_go_reg <= 1'b1;
                        state_reg   <= ST_FIT;
                    end
                end
                ST_FIT:
                begin
                    if (n_done)
                    begin
                        cross_go_reg <= 1'b1;
                        state_reg    <= ST_CROSS2;
                    end
                end
                ST_CROSS2:
                begin
                    if (x_done)
                    begin
                        norm_go_reg <= 1'b1;
                        state_reg   <= ST_NNORM;
                    end
                end
                ST_NNORM:
                begin
                    if (n_done)
                    begin
                        cross_go_reg <= 1'b1;
                        state_reg    <= ST_BCROSS;
                    end
                end
                ST_BCROSS:
                begin
                    if (x_done)
                    begin
                        norm_go_reg <= 1'b1;
                        state_reg   <= ST_BNORM;
                    end
                end
                ST_BNORM:
                begin
                    if (n_done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg   <= 1'b1;
                        seen_reg <= 2'd2;
                        for (int k = 0; k < 3; k++)
                        begin
                            pt_reg[k] <= t_reg[k];
                            pn_reg[k] <= n_reg[k];
                        end
                        if (fin_reg && !pass_reg)
                        begin
                            pass_reg  <= 1'b1;
                            first_reg <= 1'b0;
                            state_reg <= ST_SETUP;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            if (fin_reg)
                            begin
                                seen_reg <= '0;
                                for (int k = 0; k < 3; k++)
                                begin
                                    held_reg[k] <= '0;
                                    pt_reg[k]   <= '0;
                                    pn_reg[k]   <= '0;
                                end
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working vectors and output payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                for (int k = 0; k < 3; k++)
                    raw_reg[k] <= cfm_pkg::RAW_W'(pin[k]) - cfm_pkg::RAW_W'(held_reg[k]);
            end
            ST_DEGEN:
            begin
                if (out_free)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ot_reg[k] <= '0;
                        on_reg[k] <= '0;
                        ob_reg[k] <= '0;
                    end
                    olast_reg <= 1'b1;
                    odeg_reg  <= 1'b1;
                end
            end
            ST_TAN:
            begin
                if (n_done)
                    t_reg <= nres;
            end
            ST_SETUP:
            begin
                if (first_reg)
                begin
                    raw_reg[0] <= '0;
                    raw_reg[1] <= cfm_pkg::RAW_W'(t_reg[2]);
                    raw_reg[2] <= -cfm_pkg::RAW_W'(t_reg[1]);
                end
                else if (diff_zero)
                begin
                    raw_reg[0] <= '0;
                    raw_reg[1] <= cfm_pkg::RAW_W'(pt_reg[2]);
                    raw_reg[2] <= -cfm_pkg::RAW_W'(pt_reg[1]);
                end
                else
                    raw_reg <= diff;
            end
            ST_CROSS1, ST_CROSS2, ST_BCROSS:
            begin
                if (x_done)
                    raw_reg <= xo;
            end
            ST_FIT:
            begin
                if (n_done)
                    sc_reg <= nfit;
            end
            ST_NNORM:
            begin
                if (n_done)
                    n_reg <= nres;
            end
            ST_BNORM:
            begin
                if (n_done)
                    b_reg <= nres;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ot_reg    <= t_reg;
                    on_reg    <= n_reg;
                    ob_reg    <= b_reg;
                    olast_reg <= fin_reg && pass_reg;
                    odeg_reg  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // ports
    assign in_ch.ready       = state_reg == ST_IDLE;
    assign out_ch.valid      = ov_reg;
    assign out_ch.tangent_x  = ot_reg[0];
    assign out_ch.tangent_y  = ot_reg[1];
    assign out_ch.tangent_z  = ot_reg[2];
    assign out_ch.normal_x   = on_reg[0];
    assign out_ch.normal_y   = on_reg[1];
    assign out_ch.normal_z   = on_reg[2];
    assign out_ch.binormal_x = ob_reg[0];
    assign out_ch.binormal_y = ob_reg[1];
    assign out_ch.binormal_z = ob_reg[2];
    assign out_ch.frame_last = olast_reg;
    assign out_ch.degenerate = odeg_reg;

endmodule

FILE: design/cfm_cross.sv
// cross product over one shared multiplier, one partial product per cycle
module cfm_cross
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  cfm_pkg::comp_t   a [3],
    input  cfm_pkg::wide_t   b [3],
    output cfm_pkg::raw_t    o [3],
    output logic             done
);

    logic                      busy_reg;
    logic [2:0]                cnt_reg;
    logic                      done_reg;
    logic signed [cfm_pkg::OUT_W+cfm_pkg::BW-1:0] prod_reg;
    cfm_pkg::raw_t             acc_reg [3];
    logic [1:0]                ia;
    logic [1:0]                ib;
    logic [2:0]                step;
    logic [1:0]                j;

    // operand indices for each partial product
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin ia = 2'd1; ib = 2'd2; end
            3'd1:    begin ia = 2'd2; ib = 2'd1; end
            3'd2:    begin ia = 2'd2; ib = 2'd0; end
            3'd3:    begin ia = 2'd0; ib = 2'd2; end
            3'd4:    begin ia = 2'd0; ib = 2'd1; end
            3'd5:    begin ia = 2'd1; ib = 2'd0; end
            default: begin ia = 2'd0; ib = 2'd0; end
        endcase
        step = cnt_reg - 3'd1;
        j    = step[2:1];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd6);
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd6)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // multiply then accumulate the previous product
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (cnt_reg < 3'd6)
                prod_reg <= a[ia] * b[ib];
            if (cnt_reg != 3'd0)
            begin
                if (!step[0])
                    acc_reg[j] <= cfm_pkg::RAW_W'(prod_reg);
                else
                    acc_reg[j] <= acc_reg[j] - cfm_pkg::RAW_W'(prod_reg);
            end
        end
    end

    assign o    = acc_reg;
    assign done = done_reg;

endmodule

FILE: design/cfm_norm.sv
// vector normalizer: bit-serial fit shift, squares, square root, division; fit-only mode stops after the shift
module cfm_norm
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic             fit_only,
    input  cfm_pkg::raw_t    vec [3],
    output cfm_pkg::comp_t   res [3],
    output cfm_pkg::wide_t   fit [3],
    output logic             done
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_LOAD  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    logic [2:0]                    state_reg;
    logic                          done_reg;
    logic                          fit_only_reg;
    logic [cfm_pkg::RAW_W-1:0]     mag_reg [3];
    logic                          neg_reg [3];
    logic [1:0]                    cnt_reg;
    logic [2*cfm_pkg::FIT_W-1:0]   sq_reg;
    logic [cfm_pkg::SUM_W-1:0]     sum_reg;
    logic [cfm_pkg::SUM_W-1:0]     x_reg;
    logic [cfm_pkg::SUM_W-1:0]     r_reg;
    logic [cfm_pkg::SUM_W-1:0]     bit_reg;
    logic [cfm_pkg::N_W-1:0]       n_reg;
    logic [cfm_pkg::NUM_W-1:0]     num_reg;
    logic [cfm_pkg::N_W-1:0]       rem_reg;
    logic [cfm_pkg::Q_W-1:0]       q_reg;
    logic [cfm_pkg::DCNT_W-1:0]    dcnt_reg;
    cfm_pkg::comp_t                res_reg [3];

    logic                          any_high;
    logic                          all_low;
    logic                          is_zero;
    logic [cfm_pkg::SUM_W-1:0]     trial;
    logic [cfm_pkg::SUM_W-1:0]     r_next;
    logic [cfm_pkg::N_W:0]         rem_sh;
    logic                          qb;
    logic [cfm_pkg::Q_W-1:0]       q_next;
    logic [cfm_pkg::OUT_W-1:0]     q_ext;

    // range checks for the fit shift
    always_comb
    begin
        any_high = 1'b0;
        all_low  = 1'b1;
        is_zero  = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            any_high = any_high | (|mag_reg[k][cfm_pkg::RAW_W-1:cfm_pkg::FIT_W]);
            all_low  = all_low & ~mag_reg[k][cfm_pkg::FIT_W-1];
            is_zero  = is_zero & (vec[k] == '0);
        end
    end

    // square root and divider steps
    always_comb
    begin
        trial  = r_reg + bit_reg;
        r_next = (x_reg >= trial) ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
        rem_sh = {rem_reg, num_reg[cfm_pkg::NUM_W-1]};
        qb     = rem_sh >= {1'b0, n_reg};
        q_next = {q_reg[cfm_pkg::Q_W-2:0], qb};
        q_ext  = cfm_pkg::OUT_W'(q_next);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (go)
                    begin
                        if (is_zero)
                            done_reg <= 1'b1;
                        else
                            state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (!any_high && !all_low)
                    begin
                        cnt_reg <= '0;
                        if (fit_only_reg)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                            state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                        state_reg <= N_SQRT;
                end
                N_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        cnt_reg   <= '0;
                        state_reg <= N_LOAD;
                    end
                end
                N_LOAD:
                begin
                    dcnt_reg  <= cfm_pkg::DCNT_W'(cfm_pkg::NUM_W);
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == 1)
                    begin
                        if (cnt_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= N_LOAD;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (go)
                begin
                    fit_only_reg <= fit_only;
                    for (int k = 0; k < 3; k++)
                    begin
                        neg_reg[k] <= vec[k][cfm_pkg::RAW_W-1];
                        mag_reg[k] <= vec[k][cfm_pkg::RAW_W-1] ? -vec[k] : vec[k];
                        if (is_zero)
                            res_reg[k] <= '0;
                    end
                end
            end
            N_SHIFT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (any_high)
                        mag_reg[k] <= mag_reg[k] >> 1;
                    else if (all_low)
                        mag_reg[k] <= mag_reg[k] << 1;
                end
            end
            N_SQ:
            begin
                if (cnt_reg != 2'd3)
                    sq_reg <= mag_reg[cnt_reg][cfm_pkg::FIT_W-1:0] *
                              mag_reg[cnt_reg][cfm_pkg::FIT_W-1:0];
                if (cnt_reg == 2'd1)
                    sum_reg <= cfm_pkg::SUM_W'(sq_reg);
                else if (cnt_reg == 2'd2)
                    sum_reg <= sum_reg + cfm_pkg::SUM_W'(sq_reg);
                if (cnt_reg == 2'd3)
                begin
                    x_reg   <= sum_reg + cfm_pkg::SUM_W'(sq_reg);
                    r_reg   <= '0;
                    bit_reg <= cfm_pkg::SUM_W'(1) << (cfm_pkg::SUM_W - 2);
                end
            end
            N_SQRT:
            begin
                if (x_reg >= trial)
                    x_reg <= x_reg - trial;
                r_reg   <= r_next;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                    n_reg <= r_next[cfm_pkg::N_W-1:0];
            end
            N_LOAD:
            begin
                num_reg <= (cfm_pkg::NUM_W'(mag_reg[cnt_reg][cfm_pkg::FIT_W-1:0])
                            << cfm_pkg::FRAC) + cfm_pkg::NUM_W'(n_reg >> 1);
                rem_reg <= '0;
                q_reg   <= '0;
            end
            N_DIV:
            begin
                rem_reg <= qb ? cfm_pkg::N_W'(rem_sh - {1'b0, n_reg})
                              : rem_sh[cfm_pkg::N_W-1:0];
                num_reg <= num_reg << 1;
                q_reg   <= q_next;
                if (dcnt_reg == 1)
                    res_reg[cnt_reg] <= neg_reg[cnt_reg] ? -$signed(q_ext) : $signed(q_ext);
            end
            default: ;
        endcase
    end

    // results
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fit[k] = neg_reg[k] ? -$signed({1'b0, mag_reg[k][cfm_pkg::FIT_W-1:0]})
                                : $signed({1'b0, mag_reg[k][cfm_pkg::FIT_W-1:0]});
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule
